// ===== src/lpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared types, constants and codes for the lathe radius profile block.
// ----------------------------------------------------------------------------
package lpc_pkg;

  // Profile capacity and derived widths
  localparam int MaxSlices = 256;
  localparam int SliceAw   = $clog2(MaxSlices);
  localparam int IdxW      = 18;
  localparam int NumW      = 40;
  localparam int DenW      = 16;
  localparam int RadW      = 24;
  localparam int RadicW    = 48;
  localparam int QW        = 25;

  // Register reset values
  localparam logic [15:0] SliceStepReset   = 16'd1;
  localparam logic [8:0]  SliceCountReset  = 9'd256;
  localparam logic [14:0] StartRadiusReset = 15'd100;
  localparam logic [RadW-1:0] ProfileResetVal = {1'b0, StartRadiusReset, 8'b0};

  typedef enum logic [1:0] {
    OP_CUT     = 2'd0,
    OP_RESTORE = 2'd1,
    OP_READ    = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_SLICE_STEP   = 2'd0,
    CFG_SLICE_COUNT  = 2'd1,
    CFG_START_RADIUS = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIV_ZA = 2'd0,
    DIV_ZB = 2'd1,
    DIV_D  = 2'd2,
    DIV_N  = 2'd3
  } div_src_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE,
    ST_MUL_A, ST_SQRT_A, ST_WAIT_A,
    ST_MUL_B, ST_SQRT_B, ST_WAIT_B,
    ST_DIV_ZA, ST_WAIT_ZA, ST_DIV_ZB, ST_WAIT_ZB,
    ST_SETUP_A, ST_SETUP_B, ST_BRANCH,
    ST_DIV_D, ST_WAIT_D, ST_NUM_MUL, ST_DIV_N, ST_WAIT_N,
    ST_WALK_INIT, ST_WALK_RD, ST_WALK_WR,
    ST_RD_ADDR, ST_RD_TAKE, ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]        op;
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] first_z;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
    logic signed [15:0] second_z;
    logic [7:0]        slice_index;
  } in_item_t;

  typedef struct packed {
    logic [23:0] slice_radius;
    logic        out_of_range;
  } out_item_t;

  typedef struct packed {
    logic [15:0] slice_step;
    logic [8:0]  slice_count;
    logic [14:0] start_radius;
  } cfg_t;

  typedef struct packed {
    logic     capture;
    logic     pt_sel;
    logic     sq_mul;
    logic     sqrt_go;
    logic     div_go;
    div_src_e div_src;
    logic     setup_a;
    logic     setup_b;
    logic     num_mul;
    logic     walk_init;
    logic     mem_rd;
    logic     rd_item;
    logic     walk_upd;
    logic     rd_take;
    logic     set_oor;
    logic     restore;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic sqrt_done;
    logic div_done;
    logic same;
    logic empty;
    logic read_oor;
    logic walk_last;
  } stat_t;

endpackage

// ===== src/lathe_profile_cut.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lathe_profile_cut
// Radius profile of a turned part: cut, restore and read items.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o carries one item (op, two tool
//   points, slice index). Output channel out_valid_o / out_stall_i returns
//   exactly one result item per input item, in order.
//   Config writes (cfg_valid_i, cfg_ready_o always high) set slice_step,
//   slice_count and start_radius; write them only while the block is idle.
// Sequence:
//   One item at a time. Restore, no-op and out-of-range read go straight
//   to a result, a read after a registered memory read. A cut runs two
//   square roots and two divisions, two more divisions when its points
//   span several slices, then a read and a conditional write per slice
//   walked through the single-port profile memory.
// Reset:
//   All slices read as 100.0 right after reset, without a clearing pass;
//   restore needs no clearing pass either. A stalled result holds in place and no new
//   item is taken until it leaves.
// ----------------------------------------------------------------------------
module lathe_profile_cut (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lpc_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lpc_pkg::out_item_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_addr_i,
  input  logic [15:0]         cfg_data_i
);

  lpc_pkg::cfg_t  cfg_q;
  lpc_pkg::cmd_t  cmd;
  lpc_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slice_step   <= lpc_pkg::SliceStepReset;
      cfg_q.slice_count  <= lpc_pkg::SliceCountReset;
      cfg_q.start_radius <= lpc_pkg::StartRadiusReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_addr_i)
        lpc_pkg::CFG_SLICE_STEP:   cfg_q.slice_step   <= cfg_data_i;
        lpc_pkg::CFG_SLICE_COUNT:  cfg_q.slice_count  <= cfg_data_i[8:0];
        lpc_pkg::CFG_START_RADIUS: cfg_q.start_radius <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  lpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  lpc_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .item_i   (in_data_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .result_o (out_data_o)
  );

  // Never take an item while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("input open while result pending");

  // An accepted item closes the input channel
  a_accept_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not closed after accept");

  // Out-of-range reads carry zero radius
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.out_of_range) |-> (out_data_o.slice_radius == '0))
    else $error("out-of-range result with nonzero radius");

endmodule

// ===== src/lpc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          go_i,
  input  logic [lpc_pkg::NumW-1:0]      num_i,
  input  logic [lpc_pkg::DenW-1:0]      den_i,
  output logic                          done_o,
  output logic [lpc_pkg::NumW-1:0]      quo_o,
  output logic [lpc_pkg::DenW-1:0]      rem_o
);

  localparam int CntW = $clog2(lpc_pkg::NumW);

  logic                     busy_q, done_q;
  logic [CntW-1:0]          cnt_q;
  logic [lpc_pkg::NumW-1:0] sh_q;
  logic [lpc_pkg::DenW-1:0] rem_q, den_q;
  logic [lpc_pkg::DenW:0]   trial;
  logic [lpc_pkg::DenW:0]   diff;
  logic                     ge;

  // Shift in next numerator bit and try to subtract
  assign trial = {rem_q, sh_q[lpc_pkg::NumW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(lpc_pkg::NumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      sh_q  <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[lpc_pkg::DenW-1:0] : trial[lpc_pkg::DenW-1:0];
      sh_q  <= {sh_q[lpc_pkg::NumW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;
  assign rem_o  = rem_q;

endmodule

// ===== src/lpc_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_sqrt
// Integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module lpc_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        go_i,
  input  logic [lpc_pkg::RadicW-1:0]  rad_i,
  output logic                        done_o,
  output logic [lpc_pkg::RadW-1:0]    root_o
);

  localparam int Steps = lpc_pkg::RadicW / 2;
  localparam int CntW  = $clog2(Steps);
  localparam int RemW  = lpc_pkg::RadW + 2;

  logic                       busy_q, done_q;
  logic [CntW-1:0]            cnt_q;
  logic [lpc_pkg::RadicW-1:0] rad_q;
  logic [RemW-1:0]            rem_q;
  logic [lpc_pkg::RadW-1:0]   root_q;
  logic [RemW+1:0]            pull, trial, diff;
  logic                       ge;

  // Bring down two radicand bits, try root*4+1
  assign pull  = {rem_q, rad_q[lpc_pkg::RadicW-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = pull >= trial;
  assign diff  = pull - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[lpc_pkg::RadicW-3:0], 2'b00};
      rem_q  <= ge ? diff[RemW-1:0] : pull[RemW-1:0];
      root_q <= {root_q[lpc_pkg::RadW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== src/lpc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_datapath
// Point radii, slice indexes, interpolation walk and the profile memory.
// ----------------------------------------------------------------------------
module lpc_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lpc_pkg::cfg_t       cfg_i,
  input  lpc_pkg::in_item_t   item_i,
  input  lpc_pkg::cmd_t       cmd_i,
  output lpc_pkg::stat_t      stat_o,
  output lpc_pkg::out_item_t  result_o
);

  localparam int IdxW    = lpc_pkg::IdxW;
  localparam int RadW    = lpc_pkg::RadW;
  localparam int QW      = lpc_pkg::QW;
  localparam int NumW    = lpc_pkg::NumW;
  localparam int DenW    = lpc_pkg::DenW;
  localparam int SliceAw = lpc_pkg::SliceAw;

  lpc_pkg::in_item_t  item_q;
  lpc_pkg::out_item_t res_q;
  lpc_pkg::div_src_e  src_q;

  logic [31:0]              px_q, py_q;
  logic signed [15:0]       sx, sy;
  logic signed [31:0]       px_s, py_s;
  logic                     pt_q;
  logic [RadW-1:0]          ra_q, rb_q, rlo_q, rhi_q, root;
  logic signed [IdxW-1:0]   ia_q, ib_q, lo_q, hi_q, from_q, to_q, cnt_s, top_s;
  logic [DenW-1:0]          n_q, k0_q, nk, dm_q, r_q, rem;
  logic [NumW-1:0]          na_q, nb_q, na_d, nb_d, num_sum, quo, div_num;
  logic [DenW-1:0]          div_den, step_eff;
  logic [QW-1:0]            q_q, dq_q, quo_q, dq_d;
  logic [DenW-1:0]          dm_d;
  logic                     sqrt_done, div_done;
  logic [16:0]              zabs, zq_mag;
  logic signed [15:0]       zsel;
  logic [IdxW-1:0]          zq;
  logic                     zneg;
  logic [QW-1:0]            dsig;
  logic [RadW-1:0]          dabs;
  logic [DenW:0]            rsum;
  logic [SliceAw-1:0]       i_q, addr;
  logic [RadW-1:0]          mem_q [lpc_pkg::MaxSlices];
  logic [lpc_pkg::MaxSlices-1:0] vld_q;
  logic [RadW-1:0]          rdata_q, rst_val_q, cur;
  logic                     rvld_q;

  // Capture the item
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= item_i;
  end

  // Square the selected point
  assign sx   = cmd_i.pt_sel ? item_q.second_x : item_q.first_x;
  assign sy   = cmd_i.pt_sel ? item_q.second_y : item_q.first_y;
  assign px_s = sx * sx;
  assign py_s = sy * sy;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_mul) begin
      px_q <= $unsigned(px_s);
      py_q <= $unsigned(py_s);
    end
  end

  lpc_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.sqrt_go),
    .rad_i  ({px_q + py_q, 16'b0}),
    .done_o (sqrt_done),
    .root_o (root)
  );

  // Store point radius
  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_go) pt_q <= cmd_i.pt_sel;
    if (sqrt_done) begin
      if (pt_q) rb_q <= root;
      else      ra_q <= root;
    end
  end

  // Divider operand selection
  assign step_eff = (cfg_i.slice_step == '0) ? DenW'(1) : cfg_i.slice_step;
  assign zsel     = (cmd_i.div_src == lpc_pkg::DIV_ZB) ? item_q.second_z : item_q.first_z;
  assign zabs     = zsel[15] ? (17'd0 - {zsel[15], zsel}) : {1'b0, zsel};
  assign dsig     = {1'b0, rhi_q} - {1'b0, rlo_q};
  assign dabs     = dsig[QW-1] ? RadW'(QW'(0) - dsig) : dsig[RadW-1:0];
  assign num_sum  = na_q + nb_q;

  always_comb begin
    case (cmd_i.div_src)
      lpc_pkg::DIV_ZA, lpc_pkg::DIV_ZB: begin
        div_num = NumW'(zabs);
        div_den = step_eff;
      end
      lpc_pkg::DIV_D: begin
        div_num = NumW'(dabs);
        div_den = n_q;
      end
      default: begin
        div_num = num_sum;
        div_den = n_q;
      end
    endcase
  end

  lpc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.div_go),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (quo),
    .rem_o  (rem)
  );

  // Signed slice index, truncated toward zero
  assign zneg   = (src_q == lpc_pkg::DIV_ZB) ? item_q.second_z[15] : item_q.first_z[15];
  assign zq_mag = quo[16:0];
  assign zq     = zneg ? (IdxW'(0) - IdxW'(zq_mag)) : IdxW'(zq_mag);

  // Floor division of the radius difference by the slice span
  assign quo_q  = quo[QW-1:0];
  assign dq_d   = !dsig[QW-1] ? quo_q :
                  (rem == '0) ? (QW'(0) - quo_q) : (QW'(0) - quo_q - QW'(1));
  assign dm_d   = (!dsig[QW-1] || rem == '0) ? rem : (n_q - rem);

  // Active slice count and range limits
  assign cnt_s = (32'(cfg_i.slice_count) >= lpc_pkg::MaxSlices) ?
                 IdxW'(lpc_pkg::MaxSlices) : IdxW'(cfg_i.slice_count);
  assign top_s = cnt_s - IdxW'(1);

  assign nk   = n_q - k0_q;
  assign na_d = rlo_q * nk;
  assign nb_d = rhi_q * k0_q;
  assign rsum = {1'b0, r_q} + {1'b0, dm_q};

  // Profile entry as read, with never-written entries at the stock radius
  assign cur  = rvld_q ? rdata_q : rst_val_q;
  assign addr = cmd_i.rd_item ? SliceAw'(item_q.slice_index) : i_q;

  // Division results, setup and the interpolation walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_go) src_q <= cmd_i.div_src;
    if (div_done) begin
      case (src_q)
        lpc_pkg::DIV_ZA: ia_q <= zq;
        lpc_pkg::DIV_ZB: ib_q <= zq;
        lpc_pkg::DIV_D: begin
          dq_q <= dq_d;
          dm_q <= dm_d;
        end
        default: begin
          q_q <= quo_q;
          r_q <= rem;
        end
      endcase
    end
    if (cmd_i.setup_a) begin
      if (ia_q <= ib_q) begin
        lo_q  <= ia_q;
        hi_q  <= ib_q;
        rlo_q <= ra_q;
        rhi_q <= rb_q;
      end else begin
        lo_q  <= ib_q;
        hi_q  <= ia_q;
        rlo_q <= rb_q;
        rhi_q <= ra_q;
      end
    end
    if (cmd_i.setup_b) begin
      from_q <= (lo_q < 0) ? IdxW'(0) : lo_q;
      to_q   <= (hi_q < top_s) ? hi_q : top_s;
      n_q    <= DenW'(hi_q - lo_q);
      k0_q   <= (lo_q < 0) ? DenW'(IdxW'(0) - lo_q) : '0;
      if (ia_q == ib_q) begin
        q_q  <= QW'((ra_q < rb_q) ? ra_q : rb_q);
        dq_q <= '0;
        dm_q <= '0;
        r_q  <= '0;
      end
    end
    if (cmd_i.num_mul) begin
      na_q <= na_d;
      nb_q <= nb_d;
    end
    if (cmd_i.walk_init) i_q <= from_q[SliceAw-1:0];
    if (cmd_i.walk_upd) begin
      i_q <= i_q + 1'b1;
      if (rsum >= {1'b0, n_q}) begin
        r_q <= DenW'(rsum - {1'b0, n_q});
        q_q <= q_q + dq_q + QW'(1);
      end else begin
        r_q <= rsum[DenW-1:0];
        q_q <= q_q + dq_q;
      end
    end
  end

  // Profile memory: registered read, lower on walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd) rdata_q <= mem_q[addr];
    if (cmd_i.walk_upd && cur > q_q[RadW-1:0]) mem_q[i_q] <= q_q[RadW-1:0];
  end

  // Written flags and stock radius; restore drops all flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rvld_q    <= 1'b0;
      rst_val_q <= lpc_pkg::ProfileResetVal;
    end else begin
      if (cmd_i.mem_rd) rvld_q <= vld_q[addr];
      if (cmd_i.restore) begin
        vld_q     <= '0;
        rst_val_q <= {1'b0, cfg_i.start_radius, 8'b0};
      end else if (cmd_i.walk_upd && cur > q_q[RadW-1:0]) begin
        vld_q[i_q] <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (cmd_i.capture) begin
      res_q <= '0;
    end else begin
      if (cmd_i.set_oor) res_q.out_of_range <= 1'b1;
      if (cmd_i.rd_take) res_q.slice_radius <= cur;
    end
  end

  assign result_o = res_q;

  assign stat_o.op        = lpc_pkg::op_e'(item_q.op);
  assign stat_o.sqrt_done = sqrt_done;
  assign stat_o.div_done  = div_done;
  assign stat_o.same      = (ia_q == ib_q);
  assign stat_o.empty     = (from_q > to_q);
  assign stat_o.read_oor  = IdxW'(item_q.slice_index) >= $unsigned(cnt_s);
  assign stat_o.walk_last = (i_q == to_q[SliceAw-1:0]);

endmodule

// ===== src/lpc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_ctrl
// Sequencer for one item: radii, slice indexes, interpolation, walk, reads and restore.
// ----------------------------------------------------------------------------
module lpc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            out_stall_i,
  input  lpc_pkg::stat_t  stat_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  output lpc_pkg::cmd_t   cmd_o
);

  lpc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= lpc_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lpc_pkg::ST_IDLE:    if (in_valid_i) state_d = lpc_pkg::ST_DECODE;
      lpc_pkg::ST_DECODE: begin
        unique case (stat_i.op)
          lpc_pkg::OP_CUT:  state_d = lpc_pkg::ST_MUL_A;
          lpc_pkg::OP_READ: state_d = stat_i.read_oor ? lpc_pkg::ST_DONE
                                                      : lpc_pkg::ST_RD_ADDR;
          default:          state_d = lpc_pkg::ST_DONE;
        endcase
      end
      lpc_pkg::ST_MUL_A:   state_d = lpc_pkg::ST_SQRT_A;
      lpc_pkg::ST_SQRT_A:  state_d = lpc_pkg::ST_WAIT_A;
      lpc_pkg::ST_WAIT_A:  if (stat_i.sqrt_done) state_d = lpc_pkg::ST_MUL_B;
      lpc_pkg::ST_MUL_B:   state_d = lpc_pkg::ST_SQRT_B;
      lpc_pkg::ST_SQRT_B:  state_d = lpc_pkg::ST_WAIT_B;
      lpc_pkg::ST_WAIT_B:  if (stat_i.sqrt_done) state_d = lpc_pkg::ST_DIV_ZA;
      lpc_pkg::ST_DIV_ZA:  state_d = lpc_pkg::ST_WAIT_ZA;
      lpc_pkg::ST_WAIT_ZA: if (stat_i.div_done) state_d = lpc_pkg::ST_DIV_ZB;
      lpc_pkg::ST_DIV_ZB:  state_d = lpc_pkg::ST_WAIT_ZB;
      lpc_pkg::ST_WAIT_ZB: if (stat_i.div_done) state_d = lpc_pkg::ST_SETUP_A;
      lpc_pkg::ST_SETUP_A: state_d = lpc_pkg::ST_SETUP_B;
      lpc_pkg::ST_SETUP_B: state_d = lpc_pkg::ST_BRANCH;
      lpc_pkg::ST_BRANCH: begin
        if (stat_i.empty)     state_d = lpc_pkg::ST_DONE;
        else if (stat_i.same) state_d = lpc_pkg::ST_WALK_INIT;
        else                  state_d = lpc_pkg::ST_DIV_D;
      end
      lpc_pkg::ST_DIV_D:   state_d = lpc_pkg::ST_WAIT_D;
      lpc_pkg::ST_WAIT_D:  if (stat_i.div_done) state_d = lpc_pkg::ST_NUM_MUL;
      lpc_pkg::ST_NUM_MUL: state_d = lpc_pkg::ST_DIV_N;
      lpc_pkg::ST_DIV_N:   state_d = lpc_pkg::ST_WAIT_N;
      lpc_pkg::ST_WAIT_N:  if (stat_i.div_done) state_d = lpc_pkg::ST_WALK_INIT;
      lpc_pkg::ST_WALK_INIT: state_d = lpc_pkg::ST_WALK_RD;
      lpc_pkg::ST_WALK_RD: state_d = lpc_pkg::ST_WALK_WR;
      lpc_pkg::ST_WALK_WR: state_d = stat_i.walk_last ? lpc_pkg::ST_DONE
                                                      : lpc_pkg::ST_WALK_RD;
      lpc_pkg::ST_RD_ADDR: state_d = lpc_pkg::ST_RD_TAKE;
      lpc_pkg::ST_RD_TAKE: state_d = lpc_pkg::ST_DONE;
      lpc_pkg::ST_DONE:    if (!out_stall_i) state_d = lpc_pkg::ST_IDLE;
      default:             state_d = lpc_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o         = '0;
    cmd_o.div_src = lpc_pkg::DIV_ZA;
    unique case (state_q)
      lpc_pkg::ST_IDLE:   cmd_o.capture = in_valid_i;
      lpc_pkg::ST_DECODE: begin
        cmd_o.restore = (stat_i.op == lpc_pkg::OP_RESTORE);
        cmd_o.set_oor = (stat_i.op == lpc_pkg::OP_READ) && stat_i.read_oor;
      end
      lpc_pkg::ST_MUL_A:  cmd_o.sq_mul = 1'b1;
      lpc_pkg::ST_SQRT_A: cmd_o.sqrt_go = 1'b1;
      lpc_pkg::ST_MUL_B: begin
        cmd_o.sq_mul = 1'b1;
        cmd_o.pt_sel = 1'b1;
      end
      lpc_pkg::ST_SQRT_B: begin
        cmd_o.sqrt_go = 1'b1;
        cmd_o.pt_sel  = 1'b1;
      end
      lpc_pkg::ST_DIV_ZA: cmd_o.div_go = 1'b1;
      lpc_pkg::ST_DIV_ZB: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_src = lpc_pkg::DIV_ZB;
      end
      lpc_pkg::ST_SETUP_A: cmd_o.setup_a = 1'b1;
      lpc_pkg::ST_SETUP_B: cmd_o.setup_b = 1'b1;
      lpc_pkg::ST_DIV_D: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_src = lpc_pkg::DIV_D;
      end
      lpc_pkg::ST_NUM_MUL: cmd_o.num_mul = 1'b1;
      lpc_pkg::ST_DIV_N: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_src = lpc_pkg::DIV_N;
      end
      lpc_pkg::ST_WALK_INIT: cmd_o.walk_init = 1'b1;
      lpc_pkg::ST_WALK_RD:   cmd_o.mem_rd = 1'b1;
      lpc_pkg::ST_WALK_WR:   cmd_o.walk_upd = 1'b1;
      lpc_pkg::ST_RD_ADDR: begin
        cmd_o.mem_rd  = 1'b1;
        cmd_o.rd_item = 1'b1;
      end
      lpc_pkg::ST_RD_TAKE: cmd_o.rd_take = 1'b1;
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != lpc_pkg::ST_IDLE);
  assign out_valid_o = (state_q == lpc_pkg::ST_DONE);

endmodule

// ===== verif/lpc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_checker
// Watches the item, result and register channels of the lathe profile block,
// keeps its own copy of the radius profile and compares every result.
// ----------------------------------------------------------------------------
module lpc_checker
  import lpc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  in_item_t   in_data_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  out_item_t  out_data_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [1:0] cfg_addr_i,
  input  logic [15:0] cfg_data_i,
  output int         pending_o,
  output int         fails_o
);

  logic [15:0]     step_q;
  logic [8:0]      count_q;
  logic [14:0]     stock_q;
  logic [RadW-1:0] profile_q [MaxSlices];
  out_item_t       expected_q [$];

  initial begin
    step_q  = SliceStepReset;
    count_q = SliceCountReset;
    stock_q = StartRadiusReset;
    for (int i = 0; i < MaxSlices; i++) profile_q[i] = ProfileResetVal;
    fails_o = 0;
  end

  assign pending_o = expected_q.size();

  // Exact integer square root of (x*x + y*y) << 16, i.e. Q16.8 radius
  function automatic logic [RadW-1:0] tool_radius(logic signed [15:0] x,
                                                  logic signed [15:0] y);
    longint sx, sy;
    longint unsigned rem, res, b;
    sx = x;
    sy = y;
    rem = longint'(sx * sx + sy * sy) << 16;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[RadW-1:0];
  endfunction

  function automatic int slices_in_use();
    return (count_q < MaxSlices) ? int'(count_q) : MaxSlices;
  endfunction

  // Keep the smaller radius in one slice, skip slices out of range
  function automatic void trim_slice(int i, logic [RadW-1:0] r);
    if (i >= 0 && i < slices_in_use() && profile_q[i] > r) profile_q[i] = r;
  endfunction

  function automatic void apply_cut(in_item_t it);
    int stp, ia, ib, lo, hi, from, upto, n;
    logic [RadW-1:0] ra, rb, rlo, rhi;
    longint unsigned num;
    stp = (step_q == 0) ? 1 : int'(step_q);
    ia = int'(it.first_z) / stp;
    ib = int'(it.second_z) / stp;
    ra = tool_radius(it.first_x, it.first_y);
    rb = tool_radius(it.second_x, it.second_y);
    if (ia == ib) begin
      trim_slice(ia, (ra < rb) ? ra : rb);
    end else begin
      if (ia < ib) begin
        lo = ia; hi = ib; rlo = ra; rhi = rb;
      end else begin
        lo = ib; hi = ia; rlo = rb; rhi = ra;
      end
      n = hi - lo;
      from = (lo < 0) ? 0 : lo;
      upto = (hi < slices_in_use() - 1) ? hi : slices_in_use() - 1;
      for (int i = from; i <= upto; i++) begin
        num = longint'(rlo) * longint'(n - (i - lo)) + longint'(rhi) * longint'(i - lo);
        trim_slice(i, RadW'(num / longint'(n)));
      end
    end
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    int idx;
    r = '0;
    case (op_e'(it.op))
      OP_CUT: apply_cut(it);
      OP_RESTORE: begin
        for (int i = 0; i < MaxSlices; i++) profile_q[i] = {1'b0, stock_q, 8'b0};
      end
      OP_READ: begin
        idx = it.slice_index;
        if (idx < slices_in_use()) r.slice_radius = profile_q[idx];
        else r.out_of_range = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Track register writes, predict accepted items, compare results
  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_addr_i))
          CFG_SLICE_STEP:   step_q  = cfg_data_i;
          CFG_SLICE_COUNT:  count_q = cfg_data_i[8:0];
          CFG_START_RADIUS: stock_q = cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(predict_result(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with no item pending, got radius %0d oor %0b",
                   $time, out_data_i.slice_radius, out_data_i.out_of_range);
          fails_o++;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_data_i.slice_radius !== exp_r.slice_radius) begin
            $display("%0t: slice_radius expected %0d actual %0d", $time,
                     exp_r.slice_radius, out_data_i.slice_radius);
            fails_o++;
          end
          if (out_data_i.out_of_range !== exp_r.out_of_range) begin
            $display("%0t: out_of_range expected %0b actual %0b", $time,
                     exp_r.out_of_range, out_data_i.out_of_range);
            fails_o++;
          end
        end
      end
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives cut, restore and read items and register settings into the lathe
// profile block under random sender gaps and receiver stalls; the checker
// predicts each result and the top reports the verdict.
// ----------------------------------------------------------------------------
module tb;
  import lpc_pkg::*;

  localparam int CycleLimit = 8_000_000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_addr = CFG_SLICE_STEP;
  logic [15:0] cfg_data = '0;
  int         pending, fails;
  int         send_gap_pct = 0, recv_stall_pct = 0;
  int         cycles = 0, n_cuts = 0, n_reads = 0, n_items = 0, n_cfgs = 0;
  int         cur_step = 1, cur_count = 256, cur_stock = 100;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  lathe_profile_cut i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_addr_i(cfg_addr), .cfg_data_i(cfg_data)
  );

  lpc_checker i_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_addr_i(cfg_addr), .cfg_data_i(cfg_data),
    .pending_o(pending), .fails_o(fails)
  );

  // Random receiver stall
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Present one item, with an optional gap first, and hold until taken
  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat (1 + $urandom_range(3)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (in_stall);
    n_items++;
    if (it.op == OP_CUT) n_cuts++;
    if (it.op == OP_READ) n_reads++;
  endtask

  // Drain, then write all three registers
  task automatic set_regs(int stp, int cnt, int stock);
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_addr  <= CFG_SLICE_STEP;
    cfg_data  <= 16'(stp);
    do @(posedge clk_i); while (!cfg_ready);
    cfg_addr  <= CFG_SLICE_COUNT;
    cfg_data  <= 16'(cnt);
    do @(posedge clk_i); while (!cfg_ready);
    cfg_addr  <= CFG_START_RADIUS;
    cfg_data  <= 16'(stock);
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_step = stp; cur_count = cnt; cur_stock = stock;
    n_cfgs++;
  endtask

  function automatic in_item_t mk(op_e op, int ax, int ay, int az,
                                  int bx, int by, int bz, int idx);
    in_item_t it;
    it.op = op;
    it.first_x = 16'(ax); it.first_y = 16'(ay); it.first_z = 16'(az);
    it.second_x = 16'(bx); it.second_y = 16'(by); it.second_z = 16'(bz);
    it.slice_index = 8'(idx);
    return it;
  endfunction

  // Coordinate near the stock surface, or anywhere
  function automatic logic [15:0] rand_xy();
    int r;
    r = (cur_stock < 4) ? 4 : cur_stock;
    if (r > 30000) r = 30000;
    if ($urandom_range(1)) return 16'($urandom_range(0, 2 * r) - r);
    return 16'($urandom);
  endfunction

  // Axial position mostly across the slices in use
  function automatic logic [15:0] rand_z();
    longint span;
    span = longint'(cur_step == 0 ? 1 : cur_step) * (cur_count + 2);
    if (span > 32767) span = 32767;
    if ($urandom_range(9) < 8) return 16'(int'($urandom_range(0, int'(span))) - 4);
    return 16'($urandom);
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int sel;
    it = '0;
    it.slice_index = 8'($urandom);
    sel = $urandom_range(99);
    if (sel < 50) begin
      it.op = OP_CUT;
      it.first_x = rand_xy(); it.first_y = rand_xy(); it.first_z = rand_z();
      it.second_x = rand_xy(); it.second_y = rand_xy();
      it.second_z = ($urandom_range(3) == 0) ? it.first_z : rand_z();
    end else if (sel < 88) begin
      it.op = OP_READ;
      if ($urandom_range(1)) it.slice_index = 8'($urandom_range(0, 255));
    end else if (sel < 94) begin
      it.op = OP_RESTORE;
    end else begin
      it.op = OP_NONE;
      it.first_x = 16'($urandom);
    end
    return it;
  endfunction

  initial begin
    int steps [6]  = '{1, 65535, 0, 3, 200, 7};
    int counts [6] = '{256, 1, 511, 40, 0, 255};
    int stocks [6] = '{100, 0, 32767, 500, 1000, 32767};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset profile, extremes, both cut kinds, ranges, every op
    send_item(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(OP_READ, 0, 0, 0, 0, 0, 0, 255));
    send_item(mk(OP_CUT, -32768, -32768, 5, 32767, 32767, 5, 0));
    send_item(mk(OP_CUT, 30, 40, 10, 60, 80, 10, 0));
    send_item(mk(OP_READ, 0, 0, 0, 0, 0, 0, 10));
    send_item(mk(OP_CUT, 10, 0, 20, 90, 0, 60, 0));
    send_item(mk(OP_CUT, 0, 5, 200, 0, 70, 100, 0));
    send_item(mk(OP_CUT, 3, 4, -50, 7, 0, 40, 0));
    send_item(mk(OP_CUT, 1, 1, 250, 2, 2, 32767, 0));
    send_item(mk(OP_CUT, 0, 0, -32768, 0, 0, -5, 0));
    send_item(mk(OP_READ, 0, 0, 0, 0, 0, 0, 30));
    send_item(mk(OP_READ, 0, 0, 0, 0, 0, 0, 150));
    send_item(mk(OP_NONE, -1, -1, -1, -1, -1, -1, 255));
    send_item(mk(OP_RESTORE, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(OP_READ, 0, 0, 0, 0, 0, 0, 10));
    set_regs(0, 0, 0);
    send_item(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(OP_CUT, 1, 1, 0, 1, 1, 3, 0));
    set_regs(65535, 511, 32767);
    send_item(mk(OP_READ, 0, 0, 0, 0, 0, 0, 255));
    send_item(mk(OP_RESTORE, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(OP_CUT, 100, 0, -32768, 200, 0, 32767, 0));
    send_item(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0));

    // Random: six register settings over three idling phases
    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin send_gap_pct = 11; recv_stall_pct = 55; end
        1: begin send_gap_pct = 55; recv_stall_pct = 11; end
        default: begin send_gap_pct = 0; recv_stall_pct = 0; end
      endcase
      set_regs(steps[seg], counts[seg], stocks[seg]);
      send_item(mk(OP_RESTORE, 0, 0, 0, 0, 0, 0, 0));
      repeat (300) send_item(rand_item());
    end

    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (50) @(posedge clk_i);
    $display("Covered %0d items (%0d cuts, %0d reads) over %0d register settings",
             n_items, n_cuts, n_reads, n_cfgs);
    $display("under sender gaps, receiver stalls and full-rate stretches.");
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/lpc_pkg.sv
src/lpc_div.sv
src/lpc_sqrt.sv
src/lpc_datapath.sv
src/lpc_ctrl.sv
src/lathe_profile_cut.sv
verif/lpc_checker.sv
verif/tb.sv
